/* design/descriptor_slot_allocator_deferred_free_top_assert.svh */
// Assertion macros for the descriptor slot allocator top level.
// Depends on nothing; included by descriptor_slot_allocator_deferred_free_top.sv.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_DEFERRED_FREE_TOP_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_DEFERRED_FREE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("descriptor slot allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("descriptor slot allocator assertion failed");

`endif

/* design/dsa_pkg.sv */
// Package of the descriptor slot allocator: sizes, codes, types and the
// reset image of the slot bitmaps. Depends on nothing.
package dsa_pkg;

    localparam int TEX_SLOT_COUNT = 1024;
    localparam int RESERVED_SLOTS = 3;
    localparam int SAMPLER_SLOTS  = 64;
    localparam int SAMPLER_FIXED  = 2;
    localparam int FRAMES         = 2;
    localparam int RETIRE_DEPTH   = 16;

    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = SLOT_W + KIND_W;

    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int TEX_WORDS  = (TEX_SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int SAMP_WORDS = (SAMPLER_SLOTS + WORD_W - 1) / WORD_W;
    localparam int BMP_WORDS  = TEX_WORDS + SAMP_WORDS;
    localparam int BMP_AW     = $clog2(BMP_WORDS);
    localparam int MAX_WORDS  = (TEX_WORDS > SAMP_WORDS) ? TEX_WORDS : SAMP_WORDS;
    localparam int WIDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int HINT_W     = $clog2(TEX_SLOT_COUNT + 1);

    localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RD_AW     = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RETIRE_DEPTH + 1);
    localparam int RET_AW    = FRAME_W + RD_AW;
    localparam int RET_DEPTH = 1 << RET_AW;

    localparam logic [KIND_W-1:0] KIND_2D   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CUBE = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TEX_ALLOC  = 2'd0,
        MODE_RETIRE     = 2'd1,
        MODE_END_FRAME  = 2'd2,
        MODE_SAMP_ALLOC = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_TRD,
        S_TCHK,
        S_SRD,
        S_SCHK,
        S_RET,
        S_EFRM,
        S_ERD,
        S_EWRD,
        S_ECLR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              valid_res;
        logic [SLOT_W-1:0] slot_out;
        logic [KIND_W-1:0] fallback_kind;
        logic              overflow;
        logic              frame_now;
        logic              last;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [BMP_AW-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [BMP_AW-1:0] raddr;
    } t_bmp_req;

    typedef struct packed {
        logic               we;
        logic [RET_AW-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [RET_AW-1:0]  raddr;
    } t_ret_req;

    // Contents of a bitmap word that has not been written since reset.
    // Reserved and fixed slots read as taken, and so do bits past the end.
    function automatic logic [WORD_W-1:0] rst_word(input logic [BMP_AW-1:0] a);
        logic [WORD_W-1:0] w;
        int s;
        w = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (int'(a) < TEX_WORDS) begin
                s = int'(a) * WORD_W + j;
                w[j] = (s < RESERVED_SLOTS) || (s >= TEX_SLOT_COUNT);
            end else begin
                s = (int'(a) - TEX_WORDS) * WORD_W + j;
                w[j] = (s < SAMPLER_FIXED) || (s >= SAMPLER_SLOTS);
            end
        end
        return w;
    endfunction

endpackage

/* design/dsa_in_if.sv */
// Input channel of the descriptor slot allocator: handshake and item fields.
// Depends on dsa_pkg.
interface dsa_in_if import dsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] view_kind;

    modport source(output valid, mode, slot, view_kind, input ready);
    modport sink(input valid, mode, slot, view_kind, output ready);
endinterface

/* design/dsa_out_if.sv */
// Result channel of the descriptor slot allocator: handshake and result fields.
// Depends on dsa_pkg.
interface dsa_out_if import dsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              valid_res;
    logic [SLOT_W-1:0] slot_out;
    logic [KIND_W-1:0] fallback_kind;
    logic              overflow;
    logic              frame_now;
    logic              last;

    modport source(output valid, valid_res, slot_out, fallback_kind, overflow, frame_now,
                   last, input ready);
    modport sink(input valid, valid_res, slot_out, fallback_kind, overflow, frame_now,
                 last, output ready);
endinterface

/* design/descriptor_slot_allocator_deferred_free_top.sv */
// Descriptor slot allocator top over dsa_pkg: dsa_ctrl with bitmap and retire list dsa_ram.
// Texture allocate scans 32-slot words of the bitmap (up to 64 words over two passes);
// sampler allocate scans the sampler words; end frame frees each queued slot in turn.
// One beat is taken at a time, and a stall on the result holds the block.
// Synchronous reset clears the per-word valid bits, so the bitmaps read as their
// reset image at once and the block is ready right after reset.
`include "descriptor_slot_allocator_deferred_free_top_assert.svh"
module descriptor_slot_allocator_deferred_free_top import dsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsa_in_if.sink    i_in,
    dsa_out_if.source o_out
);
    t_bmp_req           bmp_req;
    t_ret_req           ret_req;
    logic [WORD_W-1:0]  bmp_q;
    logic [ENTRY_W-1:0] ret_q;

    dsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_bmp_req (bmp_req),
        .i_bmp_q   (bmp_q),
        .o_ret_req (ret_req),
        .i_ret_q   (ret_q)
    );

    dsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BMP_WORDS)
    ) u_bmp_ram (
        .i_clk   (i_clk),
        .i_we    (bmp_req.we),
        .i_waddr (bmp_req.waddr),
        .i_wdata (bmp_req.wdata),
        .i_raddr (bmp_req.raddr),
        .o_rdata (bmp_q)
    );

    dsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RET_DEPTH)
    ) u_ret_ram (
        .i_clk   (i_clk),
        .i_we    (ret_req.we),
        .i_waddr (ret_req.waddr),
        .i_wdata (ret_req.wdata),
        .i_raddr (ret_req.raddr),
        .o_rdata (ret_q)
    );

    `DSA_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `DSA_ASSERT_IMP(a_ovf_not_valid, i_clk, i_rst_n, o_out.valid && o_out.overflow, !o_out.valid_res)
    `DSA_ASSERT_IMP(a_kind_known, i_clk, i_rst_n, o_out.valid, o_out.fallback_kind <= KIND_CUBE)
endmodule

/* design/dsa_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module dsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

/* design/dsa_find.sv */
// Finds the lowest clear bit of a bitmap word at or above a start position.
// Depends on dsa_pkg.
module dsa_find import dsa_pkg::*; (
    input  logic [WORD_W-1:0] i_word,
    input  logic [BIT_W-1:0]  i_lo,
    output logic              o_found,
    output logic [BIT_W-1:0]  o_bit
);
    logic [WORD_W-1:0] masked;

    always_comb begin
        masked  = i_word | ((WORD_W'(1) << i_lo) - WORD_W'(1));
        o_found = 1'b0;
        o_bit   = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (!masked[j]) begin
                o_found = 1'b1;
                o_bit   = BIT_W'(j);
            end
        end
    end
endmodule

/* design/dsa_ctrl.sv */
// Sequencer of the descriptor slot allocator: word scans of the bitmap memory,
// retire list handling, frame drain and the result register.
// Depends on dsa_pkg, dsa_find, dsa_in_if and dsa_out_if.
module dsa_ctrl import dsa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dsa_in_if.sink             i_in,
    dsa_out_if.source          o_out,
    output t_bmp_req           o_bmp_req,
    input  logic [WORD_W-1:0]  i_bmp_q,
    output t_ret_req           o_ret_req,
    input  logic [ENTRY_W-1:0] i_ret_q
);
    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [KIND_W-1:0]   r_vk, n_vk;
    logic [HINT_W-1:0]   r_hint, n_hint;
    logic [HINT_W-1:0]   r_top, n_top;
    logic [WIDX_W-1:0]   r_word, n_word;
    logic [BIT_W-1:0]    r_lo, n_lo;
    logic                r_phase, n_phase;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [CNT_W-1:0]    r_cnt [FRAMES];
    logic [CNT_W-1:0]    n_cnt [FRAMES];
    logic [CNT_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [SLOT_W-1:0]   r_eslot, n_eslot;
    logic [KIND_W-1:0]   r_ekind, n_ekind;
    t_res                r_res, n_res;
    logic                r_ovld, n_ovld;
    t_res                r_opay, n_opay;
    logic [BMP_WORDS-1:0] r_wvld;
    logic                r_rd_vld;
    logic [BMP_AW-1:0]   r_rd_addr;

    logic [WORD_W-1:0]        eff_word;
    logic                     f_found;
    logic [BIT_W-1:0]         f_bit;
    logic [WIDX_W+BIT_W-1:0]  f_idx;
    logic                     tex_last;
    logic                     samp_last;
    logic                     tex_fit;
    logic                     out_free;
    logic                     in_acc;
    logic [KIND_W-1:0]        kind_map;

    assign eff_word  = r_rd_vld ? i_bmp_q : rst_word(r_rd_addr);
    assign f_idx     = {r_word, f_bit};
    assign tex_last  = (r_word == WIDX_W'(TEX_WORDS - 1));
    assign samp_last = (r_word == WIDX_W'(SAMP_WORDS - 1));
    assign tex_fit   = !r_phase || (HINT_W'(f_idx) < r_top);
    assign out_free  = !r_ovld || o_out.ready;
    assign in_acc    = i_in.valid && (r_state == S_IDLE);
    assign kind_map  = (r_vk <= KIND_CUBE) ? r_vk : KIND_2D;

    dsa_find u_find (
        .i_word  (eff_word),
        .i_lo    (r_lo),
        .o_found (f_found),
        .o_bit   (f_bit)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                unique case (r_mode)
                    MODE_TEX_ALLOC:  n_state = S_TRD;
                    MODE_SAMP_ALLOC: n_state = S_SRD;
                    MODE_RETIRE:     n_state = S_RET;
                    MODE_END_FRAME:  n_state = S_EFRM;
                    default:         n_state = S_IDLE;
                endcase
            end
            S_TRD:  n_state = S_TCHK;
            S_TCHK: begin
                if (f_found || (r_phase && tex_last)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_TRD;
                end
            end
            S_SRD:  n_state = S_SCHK;
            S_SCHK: begin
                if (f_found || samp_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_RET:  n_state = S_EMIT;
            S_EFRM: begin
                if (r_cnt[r_frame] == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_ERD:  n_state = S_EWRD;
            S_EWRD: n_state = S_ECLR;
            S_ECLR: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_res.last ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic [HINT_W-1:0] top;
        top = (r_hint < HINT_W'(TEX_SLOT_COUNT)) ? r_hint : HINT_W'(TEX_SLOT_COUNT);

        i_in.ready = i_rst_n && (r_state == S_IDLE);
        n_mode  = r_mode;
        n_slot  = r_slot;
        n_vk    = r_vk;
        n_hint  = r_hint;
        n_top   = r_top;
        n_word  = r_word;
        n_lo    = r_lo;
        n_phase = r_phase;
        n_frame = r_frame;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_k     = r_k;
        n_eslot = r_eslot;
        n_ekind = r_ekind;
        n_res   = r_res;
        n_ovld  = r_ovld && !o_out.ready;
        n_opay  = r_opay;

        o_bmp_req.we    = 1'b0;
        o_bmp_req.waddr = BMP_AW'(r_word);
        o_bmp_req.wdata = eff_word;
        o_bmp_req.raddr = BMP_AW'(r_word);
        o_ret_req.we    = 1'b0;
        o_ret_req.waddr = {r_frame, r_cnt[r_frame][RD_AW-1:0]};
        o_ret_req.wdata = {r_slot, kind_map};
        o_ret_req.raddr = {r_frame, r_k[RD_AW-1:0]};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode = t_mode'(i_in.mode);
                    n_slot = i_in.slot;
                    n_vk   = i_in.view_kind;
                end
            end
            S_START: begin
                unique case (r_mode)
                    MODE_TEX_ALLOC: begin
                        n_top = top;
                        if (top == HINT_W'(TEX_SLOT_COUNT)) begin
                            n_word  = '0;
                            n_lo    = BIT_W'(RESERVED_SLOTS);
                            n_phase = 1'b1;
                        end else begin
                            n_word  = WIDX_W'(top >> BIT_W);
                            n_lo    = top[BIT_W-1:0];
                            n_phase = 1'b0;
                        end
                    end
                    MODE_SAMP_ALLOC: begin
                        n_word = '0;
                        n_lo   = '0;
                    end
                    MODE_END_FRAME: begin
                        n_frame = (r_frame == FRAME_W'(FRAMES - 1)) ? '0 : r_frame + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_TRD: begin
            end
            S_TCHK: begin
                n_res = '{valid_res: 1'b0, slot_out: '0, fallback_kind: KIND_2D,
                          overflow: 1'b0, frame_now: r_frame[0], last: 1'b1};
                if (f_found && tex_fit) begin
                    o_bmp_req.we    = 1'b1;
                    o_bmp_req.wdata = eff_word | (WORD_W'(1) << f_bit);
                    n_hint          = HINT_W'(f_idx) + 1'b1;
                    n_res.valid_res = 1'b1;
                    n_res.slot_out  = SLOT_W'(f_idx);
                end else if (!f_found && tex_last && !r_phase) begin
                    n_word  = '0;
                    n_lo    = BIT_W'(RESERVED_SLOTS);
                    n_phase = 1'b1;
                end else if (!f_found && !tex_last) begin
                    n_word = r_word + 1'b1;
                    n_lo   = '0;
                end
            end
            S_SRD: begin
                o_bmp_req.raddr = BMP_AW'(TEX_WORDS) + BMP_AW'(r_word);
            end
            S_SCHK: begin
                n_res = '{valid_res: 1'b0, slot_out: '0, fallback_kind: KIND_2D,
                          overflow: 1'b0, frame_now: r_frame[0], last: 1'b1};
                if (f_found) begin
                    o_bmp_req.we    = 1'b1;
                    o_bmp_req.waddr = BMP_AW'(TEX_WORDS) + BMP_AW'(r_word);
                    o_bmp_req.wdata = eff_word | (WORD_W'(1) << f_bit);
                    n_res.valid_res = 1'b1;
                    n_res.slot_out  = SLOT_W'(f_idx);
                end else if (!samp_last) begin
                    n_word = r_word + 1'b1;
                end
            end
            S_RET: begin
                n_res = '{valid_res: 1'b0, slot_out: r_slot, fallback_kind: KIND_2D,
                          overflow: 1'b0, frame_now: r_frame[0], last: 1'b1};
                if (r_slot < SLOT_W'(RESERVED_SLOTS) ||
                        HINT_W'(r_slot) >= HINT_W'(TEX_SLOT_COUNT)) begin
                    n_res.fallback_kind = KIND_2D;
                end else if (r_cnt[r_frame] >= CNT_W'(RETIRE_DEPTH)) begin
                    n_res.fallback_kind = kind_map;
                    n_res.overflow      = 1'b1;
                end else begin
                    o_ret_req.we        = 1'b1;
                    n_cnt[r_frame]      = r_cnt[r_frame] + 1'b1;
                    n_res.valid_res     = 1'b1;
                    n_res.fallback_kind = kind_map;
                end
            end
            S_EFRM: begin
                n_res = '{valid_res: 1'b0, slot_out: '0, fallback_kind: KIND_2D,
                          overflow: 1'b0, frame_now: r_frame[0], last: 1'b1};
                if (r_cnt[r_frame] != '0) begin
                    n_n            = r_cnt[r_frame];
                    n_k            = '0;
                    n_cnt[r_frame] = '0;
                end
            end
            S_ERD: begin
            end
            S_EWRD: begin
                n_eslot         = i_ret_q[ENTRY_W-1:KIND_W];
                n_ekind         = i_ret_q[KIND_W-1:0];
                o_bmp_req.raddr = BMP_AW'(i_ret_q[ENTRY_W-1:KIND_W] >> BIT_W);
            end
            S_ECLR: begin
                o_bmp_req.we    = 1'b1;
                o_bmp_req.waddr = BMP_AW'(r_eslot >> BIT_W);
                o_bmp_req.wdata = eff_word & ~(WORD_W'(1) << r_eslot[BIT_W-1:0]);
                n_res = '{valid_res: 1'b1, slot_out: r_eslot, fallback_kind: r_ekind,
                          overflow: 1'b0, frame_now: r_frame[0],
                          last: (r_k + 1'b1 == r_n)};
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovld = 1'b1;
                    n_opay = r_res;
                    if (!r_res.last) begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hint  <= '0;
            r_frame <= '0;
            r_ovld  <= 1'b0;
            r_wvld  <= '0;
            for (int f = 0; f < FRAMES; f++) begin
                r_cnt[f] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            r_frame <= n_frame;
            r_ovld  <= n_ovld;
            r_cnt   <= n_cnt;
            if (o_bmp_req.we) begin
                r_wvld[o_bmp_req.waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_slot    <= n_slot;
        r_vk      <= n_vk;
        r_top     <= n_top;
        r_word    <= n_word;
        r_lo      <= n_lo;
        r_phase   <= n_phase;
        r_n       <= n_n;
        r_k       <= n_k;
        r_eslot   <= n_eslot;
        r_ekind   <= n_ekind;
        r_res     <= n_res;
        r_opay    <= n_opay;
        r_rd_vld  <= r_wvld[o_bmp_req.raddr];
        r_rd_addr <= o_bmp_req.raddr;
    end

    assign o_out.valid         = r_ovld;
    assign o_out.valid_res     = r_opay.valid_res;
    assign o_out.slot_out      = r_opay.slot_out;
    assign o_out.fallback_kind = r_opay.fallback_kind;
    assign o_out.overflow      = r_opay.overflow;
    assign o_out.frame_now     = r_opay.frame_now;
    assign o_out.last          = r_opay.last;
endmodule
